// ===== hdl/tli_pkg.sv =====
// Package for the time table interpolator: widths, types, codes.
// Used by the interfaces and every module of the block.
`default_nettype none
package tli_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int SIZE_W    = 5;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = 33;
    localparam int PROD_W    = FRAC_BITS + 1 + DIFF_W;
    localparam int DCNT_W    = $clog2(FRAC_BITS + 1);

    typedef logic        [31:0]          t_time;
    typedef logic signed [31:0]          t_value;
    typedef logic        [IDX_W-1:0]     t_idx;
    typedef logic        [SIZE_W-1:0]    t_size;
    typedef logic        [2:0]           t_src;
    typedef logic        [1:0]           t_cfg_idx;
    typedef logic        [FRAC_BITS-1:0] t_weight;
    typedef logic signed [DIFF_W-1:0]    t_diff;
    typedef logic signed [PROD_W-1:0]    t_prod;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam t_src SRC_CONST  = 3'd0;
    localparam t_src SRC_FIRST  = 3'd1;
    localparam t_src SRC_EXACT  = 3'd2;
    localparam t_src SRC_INTERP = 3'd3;
    localparam t_src SRC_LAST   = 3'd4;

    localparam t_cfg_idx CFG_TABLE_SIZE = 2'd0;
    localparam t_cfg_idx CFG_CONST_MODE = 2'd1;
    localparam t_cfg_idx CFG_CONST_VAL  = 2'd2;

    typedef struct packed {
        t_size  table_size;
        logic   const_mode;
        t_value const_value;
    } t_cfg;

    typedef struct packed {
        logic  start;
        t_time num;
        t_time den;
    } t_div_req;

    typedef struct packed {
        logic    done;
        t_weight quot;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== hdl/tli_if.sv =====
// Channel interfaces: item input, result output, configuration write.
// Depends on tli_pkg.
`default_nettype none
interface tli_in_if import tli_pkg::*;;
    logic   valid;
    logic   ready;
    logic   op;
    t_idx   entry_index;
    t_time  write_time;
    t_value entry_value;
    t_time  query_time;
    modport source (output valid, op, entry_index, write_time, entry_value, query_time,
                    input ready);
    modport sink   (input valid, op, entry_index, write_time, entry_value, query_time,
                    output ready);
endinterface

interface tli_out_if import tli_pkg::*;;
    logic   valid;
    logic   ready;
    t_value result_value;
    t_src   result_source;
    modport source (output valid, result_value, result_source, input ready);
    modport sink   (input valid, result_value, result_source, output ready);
endinterface

interface tli_cfg_if import tli_pkg::*;;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_value   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/time_table_linear_interp.sv =====
// Top level of the time table interpolator: configuration registers,
// sequencer and divider. Depends on tli_pkg, tli_if, tli_div, tli_seq.
//
//  port    dir  kind                  content
//  i_in    in   tli_in_if.sink        write entry or query time
//  o_out   out  tli_out_if.source     result value and source code
//  i_cfg   in   tli_cfg_if.sink       register index and data, always ready
//
// A write is stored when accepted. A query in constant mode passes the accept and
// the output register load. A table query passes the accept, first-entry read,
// a scan of one entry at a time (at most 15), the divider (16 quotient bits and
// the done flag), the multiply and the output register load. Synchronous reset
// clears control and sets table size 1, constant mode on, constant value 0; table
// entries are undefined until written. A result waits in the output register
// while the sink stalls; the block goes idle again once it is loaded there.
`default_nettype none
module time_table_linear_interp import tli_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tli_in_if.sink    i_in,
    tli_out_if.source o_out,
    tli_cfg_if.sink   i_cfg
);

    t_size    r_table_size;
    logic     r_const_mode;
    t_value   r_const_value;
    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size  <= t_size'(1);
            r_const_mode  <= 1'b1;
            r_const_value <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TABLE_SIZE: r_table_size  <= i_cfg.data[SIZE_W-1:0];
                CFG_CONST_MODE: r_const_mode  <= i_cfg.data[0];
                CFG_CONST_VAL:  r_const_value <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.table_size  = r_table_size;
    assign cfg.const_mode  = r_const_mode;
    assign cfg.const_value = r_const_value;

    tli_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp)
    );

    tli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
`default_nettype wire

// ===== hdl/tli_div.sv =====
// Restoring divider, one quotient bit per cycle, FRAC_BITS bits of fraction.
// Needs num < den; depends on tli_pkg.
`default_nettype none
module tli_div import tli_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [32:0]       r_rem, n_rem;
    t_time             r_den, n_den;
    t_weight           r_quot, n_quot;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [32:0]       trial;

    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        trial  = {r_rem[31:0], 1'b0};
        if (i_req.start) begin
            n_rem = {1'b0, i_req.num};
            n_den = i_req.den;
            n_cnt = DCNT_W'(FRAC_BITS);
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem  = trial - {1'b0, r_den};
                n_quot = {r_quot[FRAC_BITS-2:0], 1'b1};
            end else begin
                n_rem  = trial;
                n_quot = {r_quot[FRAC_BITS-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == DCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
`default_nettype wire

// ===== hdl/tli_seq.sv =====
// Query sequencer: entry tables, span scan, multiply and output register.
// Uses tli_div for the weight; depends on tli_pkg and tli_if.
`default_nettype none
module tli_seq import tli_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    tli_in_if.sink    i_in,
    tli_out_if.source o_out,
    output t_div_req  o_div_req,
    input  wire t_div_rsp i_div_rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    t_time  r_time_mem [ENTRIES];
    t_value r_val_mem  [ENTRIES];
    t_time  r_rd_time;
    t_value r_rd_val;

    logic [2:0] r_state, n_state;
    t_time      r_q, n_q;
    t_size      r_size, n_size;
    t_idx       r_lc, n_lc;
    t_time      r_tprev, n_tprev;
    t_value     r_vprev, n_vprev;
    t_diff      r_diff, n_diff;
    t_prod      r_prod, n_prod;
    t_value     r_res_val, n_res_val;
    t_src       r_res_src, n_res_src;
    logic       r_out_valid, n_out_valid;
    t_value     r_out_val, n_out_val;
    t_src       r_out_src, n_out_src;
    logic       in_acc;
    t_size      size_clamp;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        if (i_cfg.table_size == '0)
            size_clamp = t_size'(1);
        else if (i_cfg.table_size > t_size'(ENTRIES))
            size_clamp = t_size'(ENTRIES);
        else
            size_clamp = i_cfg.table_size;
    end

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_size      = r_size;
        n_lc        = r_lc;
        n_tprev     = r_tprev;
        n_vprev     = r_vprev;
        n_diff      = r_diff;
        n_prod      = r_prod;
        n_res_val   = r_res_val;
        n_res_src   = r_res_src;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_val   = r_out_val;
        n_out_src   = r_out_src;
        o_div_req.start = 1'b0;
        o_div_req.num   = (r_q > r_tprev) ? (r_q - r_tprev) : '0;
        o_div_req.den   = r_rd_time - r_tprev;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.op == OP_QUERY) begin
                    n_q    = i_in.query_time;
                    n_size = size_clamp;
                    n_lc   = '0;
                    if (i_cfg.const_mode) begin
                        n_res_val = i_cfg.const_value;
                        n_res_src = SRC_CONST;
                        n_state   = S_EMIT;
                    end else begin
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                n_tprev = r_rd_time;
                n_vprev = r_rd_val;
                if (r_size == t_size'(1) || r_q <= r_rd_time) begin
                    n_res_val = r_rd_val;
                    n_res_src = SRC_FIRST;
                    n_state   = S_EMIT;
                end else begin
                    n_lc    = t_idx'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_q == r_rd_time) begin
                    n_res_val = r_rd_val;
                    n_res_src = SRC_EXACT;
                    n_state   = S_EMIT;
                end else if (r_q < r_rd_time) begin
                    if (r_rd_time <= r_tprev) begin
                        // span of zero or negative length: take the later value
                        n_res_val = r_rd_val;
                        n_res_src = SRC_EXACT;
                        n_state   = S_EMIT;
                    end else begin
                        o_div_req.start = 1'b1;
                        n_diff  = t_diff'(r_rd_val) - t_diff'(r_vprev);
                        n_state = S_DIV;
                    end
                end else begin
                    n_tprev = r_rd_time;
                    n_vprev = r_rd_val;
                    if ({1'b0, r_lc} == r_size - 1'b1) begin
                        n_res_val = r_rd_val;
                        n_res_src = SRC_LAST;
                        n_state   = S_EMIT;
                    end else begin
                        n_lc = r_lc + 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_prod  = $signed({1'b0, i_div_rsp.quot}) * r_diff;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // arithmetic shift floors the product, result wraps to 32 bits
                n_res_val = r_vprev + t_value'(r_prod[FRAC_BITS+31:FRAC_BITS]);
                n_res_src = SRC_INTERP;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_res_val;
                    n_out_src   = r_res_src;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.op == OP_WRITE) begin
            r_time_mem[i_in.entry_index] <= i_in.write_time;
            r_val_mem[i_in.entry_index]  <= i_in.entry_value;
        end
        r_rd_time <= r_time_mem[n_lc];
        r_rd_val  <= r_val_mem[n_lc];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_q       <= n_q;
        r_size    <= n_size;
        r_lc      <= n_lc;
        r_tprev   <= n_tprev;
        r_vprev   <= n_vprev;
        r_diff    <= n_diff;
        r_prod    <= n_prod;
        r_res_val <= n_res_val;
        r_res_src <= n_res_src;
        r_out_val <= n_out_val;
        r_out_src <= n_out_src;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_value  = r_out_val;
    assign o_out.result_source = r_out_src;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op == OP_WRITE) |=> r_state == S_IDLE)
        else $error("entry write left the idle state");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> ({1'b0, r_lc} < r_size && r_lc != '0))
        else $error("scan index outside the table in use");

    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || o_out.ready)) |=> r_out_valid)
        else $error("finished result not loaded into the output register");

endmodule
`default_nettype wire
